// ===== src/tct_pkg.sv =====
// shared types and constants of the table charset transcoder
package tct_pkg;

   localparam int SYMBOL_BYTES = 3;
   localparam int SYMBOL_WIDTH = 8 * SYMBOL_BYTES;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ENCODE = 2'd1;
   localparam logic [1:0] REQ_DECODE = 2'd2;

   localparam logic [1:0] CSR_NEWLINE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_NEWLINE_FIRST  = 2'd1;
   localparam logic [1:0] CSR_NEWLINE_SECOND = 2'd2;

   localparam logic [7:0] CODE_CR   = 8'h0d;
   localparam logic [7:0] CODE_LF   = 8'h0a;
   localparam logic [7:0] CODE_EOF  = 8'h1a;
   localparam logic [7:0] CODE_NONE = 8'h20;
   localparam logic [7:0] CONT_MASK = 8'hc0;
   localparam logic [7:0] CONT_MARK = 8'h80;

   localparam logic [1:0] NEWLINE_LENGTH_RESET = 2'd1;
   localparam logic [7:0] NEWLINE_FIRST_RESET  = 8'h0a;
   localparam logic [7:0] NEWLINE_SECOND_RESET = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENC_SELECT,
      ST_ENC_SCAN,
      ST_ENC_EMIT,
      ST_DEC_READ,
      ST_DEC_LATCH,
      ST_DEC_EMIT
   } tct_state_type;

   typedef struct packed {
      logic       ready;
      logic [1:0] job_sel;
      logic       load_special;
      logic       scan_start;
      logic       scan_run;
      logic       enc_push;
      logic       dec_latch;
      logic       dec_push;
   } tct_cmd_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] kind;
      logic       job_planned;
      logic       job_special;
      logic       job_last;
      logic       scan_hit;
      logic       scan_end;
      logic       slot_free;
      logic       dec_empty;
      logic       dec_last;
   } tct_status_type;

endpackage

// ===== src/tct_req_if.sv =====
// request channel of the transcoder
interface tct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  entry_index;
   logic [1:0]  entry_length;
   logic [23:0] entry_text;
   logic [7:0]  data_byte;
   logic        end_of_text;

   modport source (
      output valid, req_type, entry_index, entry_length, entry_text, data_byte,
             end_of_text,
      input  ready
   );
   modport sink (
      input  valid, req_type, entry_index, entry_length, entry_text, data_byte,
             end_of_text,
      output ready
   );
endinterface

// ===== src/tct_rsp_if.sv =====
// result channel of the transcoder
interface tct_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (
      output valid, out_byte, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, out_byte, last_of_run,
      output ready
   );
endinterface

// ===== src/tct_datapath.sv =====
// datapath: code table memory, encoder and decoder state, table scan, result register
module tct_datapath
   import tct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic           clock,
   input  logic           reset,
   tct_req_if.sink        req_bus,
   tct_rsp_if.source      rsp_bus,
   input  logic           csr_write_enable,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_write_data,
   input  tct_cmd_type    cmd,
   output tct_status_type status
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
   localparam logic [8:0] ENTRY_LIMIT = 9'(TABLE_ENTRIES);

   // code table
   logic [SYMBOL_WIDTH+1:0] mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [SYMBOL_WIDTH+1:0] rd_data_ff;
   logic rd_valid_ff;
   logic [AW-1:0] rd_addr;

   // configuration
   logic [1:0] nl_length_ff;
   logic [7:0] nl_first_ff;
   logic [7:0] nl_second_ff;

   // encoder state and plan
   logic [SYMBOL_WIDTH-1:0] pending_ff, pending_in;
   logic [1:0] count_ff, count_in;
   logic skip_ff, skip_in;
   logic [2:0] plan_ff, plan_in;
   logic [SYMBOL_WIDTH-1:0] sym_ff [3];
   logic [SYMBOL_WIDTH-1:0] sym_in [3];
   logic [1:0] len_ff [3];
   logic [1:0] len_in [3];

   // decoder state
   logic stopped_ff;
   logic dk_nl_ff, dk_tab_ff;
   logic [7:0] byte_ff;
   logic [SYMBOL_WIDTH-1:0] dbytes_ff;
   logic [1:0] dcount_ff, dk_ff;

   // scan
   logic [AW-1:0] scan_addr_ff, rd_idx_ff;
   logic issue_ff, live_ff;
   logic [7:0] res_ff;

   // result register
   logic rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic rsp_last_ff;

   logic accept;
   logic [7:0] b;
   logic lf_drop, pend, cont, full, done_b;
   logic [SYMBOL_WIDTH-1:0] appended;
   logic skip_mid;
   logic [SYMBOL_WIDTH-1:0] mid_pending;
   logic [1:0] mid_count;
   logic [SYMBOL_WIDTH-1:0] job_sym;
   logic [1:0] job_len;
   logic [7:0] special_val;
   logic [1:0] rd_len;
   logic [SYMBOL_WIDTH-1:0] rd_text;
   logic [SYMBOL_WIDTH-1:0] load_mask;
   logic [SYMBOL_WIDTH-1:0] dec_shifted;
   logic [1:0] nl_count;
   logic load_hit;

   assign accept = req_bus.valid && cmd.ready;
   assign req_bus.ready = cmd.ready;
   assign b = req_bus.data_byte;
   assign rd_len = rd_data_ff[SYMBOL_WIDTH+1:SYMBOL_WIDTH];
   assign rd_text = rd_data_ff[SYMBOL_WIDTH-1:0];
   assign rd_addr = cmd.scan_run ? scan_addr_ff : byte_ff[AW-1:0];
   assign load_hit = accept && (req_bus.req_type == REQ_LOAD)
                     && ({1'b0, req_bus.entry_index} < ENTRY_LIMIT);

   always_comb begin
      case (req_bus.entry_length)
         2'd0:    load_mask = '0;
         2'd1:    load_mask = SYMBOL_WIDTH'(24'h0000ff);
         2'd2:    load_mask = SYMBOL_WIDTH'(24'h00ffff);
         default: load_mask = SYMBOL_WIDTH'(24'hffffff);
      endcase
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (load_hit) begin
         mem[req_bus.entry_index[AW-1:0]] <=
            {req_bus.entry_length, req_bus.entry_text & load_mask};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (load_hit) begin
            valid_ff[req_bus.entry_index[AW-1:0]] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nl_length_ff <= NEWLINE_LENGTH_RESET;
         nl_first_ff <= NEWLINE_FIRST_RESET;
         nl_second_ff <= NEWLINE_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NEWLINE_LENGTH: nl_length_ff <= csr_write_data[1:0];
            CSR_NEWLINE_FIRST:  nl_first_ff <= csr_write_data;
            CSR_NEWLINE_SECOND: nl_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // encoder: plan up to three symbol lookups for one text byte
   always_comb begin
      lf_drop = skip_ff && (b == CODE_LF);
      pend = (count_ff != 2'd0);
      cont = ((b & CONT_MASK) == CONT_MARK);
      full = (count_ff == 2'(SYMBOL_BYTES - 1));
      appended = pending_ff | (SYMBOL_WIDTH'(b) << {count_ff, 3'b000});
      done_b = lf_drop || (pend && cont);

      // broken or completed symbol
      plan_in[0] = !lf_drop && pend && (!cont || full);
      sym_in[0] = cont ? appended : pending_ff;
      len_in[0] = cont ? count_ff + 2'd1 : count_ff;

      // plain byte
      plan_in[1] = !done_b && !b[7];
      sym_in[1] = SYMBOL_WIDTH'(b);
      len_in[1] = 2'd1;

      mid_pending = '0;
      mid_count = 2'd0;
      if (lf_drop) begin
         mid_pending = pending_ff;
         mid_count = count_ff;
      end else if (pend && cont) begin
         if (!full) begin
            mid_pending = appended;
            mid_count = count_ff + 2'd1;
         end
      end else if (b[7]) begin
         mid_pending = SYMBOL_WIDTH'(b);
         mid_count = 2'd1;
      end
      skip_mid = !done_b && (b == CODE_CR);

      // flush at end of text
      plan_in[2] = req_bus.end_of_text && (mid_count != 2'd0);
      sym_in[2] = mid_pending;
      len_in[2] = mid_count;

      pending_in = req_bus.end_of_text ? '0 : mid_pending;
      count_in = req_bus.end_of_text ? 2'd0 : mid_count;
      skip_in = req_bus.end_of_text ? 1'b0 : skip_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff <= 2'd0;
         skip_ff <= 1'b0;
         plan_ff <= 3'b000;
      end else if (accept && (req_bus.req_type == REQ_ENCODE)) begin
         pending_ff <= pending_in;
         count_ff <= count_in;
         skip_ff <= skip_in;
         plan_ff <= plan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_bus.req_type == REQ_ENCODE)) begin
         for (int j = 0; j < 3; j++) begin
            sym_ff[j] <= sym_in[j];
            len_ff[j] <= len_in[j];
         end
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
         dk_nl_ff <= 1'b0;
         dk_tab_ff <= 1'b0;
      end else if (accept && (req_bus.req_type == REQ_DECODE)) begin
         stopped_ff <= req_bus.end_of_text ? 1'b0 : (stopped_ff || (b == CODE_EOF));
         dk_nl_ff <= !stopped_ff && (b == CODE_CR);
         dk_tab_ff <= !stopped_ff && (b != CODE_EOF) && (b != CODE_CR)
                      && ({1'b0, b} < ENTRY_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= b;
      end
   end

   assign nl_count = (nl_length_ff >= 2'd2) ? 2'd2 : 2'd1;

   always_ff @(posedge clock) begin
      if (cmd.dec_latch) begin
         dk_ff <= 2'd0;
         if (dk_nl_ff) begin
            dbytes_ff <= SYMBOL_WIDTH'({nl_second_ff, nl_first_ff});
            dcount_ff <= nl_count;
         end else if (dk_tab_ff) begin
            dbytes_ff <= rd_text;
            dcount_ff <= rd_valid_ff ? rd_len : 2'd0;
         end else begin
            dcount_ff <= 2'd0;
         end
      end else if (cmd.dec_push) begin
         dk_ff <= dk_ff + 2'd1;
      end
   end

   assign dec_shifted = dbytes_ff >> {dk_ff, 3'b000};

   // table scan, one entry a cycle, lowest index first
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         live_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         issue_ff <= 1'b1;
         live_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         live_ff <= issue_ff;
         if (issue_ff && (scan_addr_ff == LAST_ADDR)) begin
            issue_ff <= 1'b0;
         end
      end else begin
         issue_ff <= 1'b0;
         live_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_run) begin
         rd_idx_ff <= scan_addr_ff;
         if (issue_ff && (scan_addr_ff != LAST_ADDR)) begin
            scan_addr_ff <= scan_addr_ff + AW'(1);
         end
      end
   end

   assign job_sym = sym_ff[cmd.job_sel];
   assign job_len = len_ff[cmd.job_sel];
   assign special_val = (job_sym == SYMBOL_WIDTH'(CODE_EOF)) ? CODE_EOF : CODE_CR;

   always_comb begin
      status.accept = accept;
      status.kind = req_bus.req_type;
      status.job_planned = plan_ff[cmd.job_sel];
      status.job_special = (job_len == 2'd1)
                           && ((job_sym == SYMBOL_WIDTH'(CODE_EOF))
                               || (job_sym == SYMBOL_WIDTH'(CODE_CR))
                               || (job_sym == SYMBOL_WIDTH'(CODE_LF)));
      case (cmd.job_sel)
         2'd0:    status.job_last = !plan_ff[1] && !plan_ff[2];
         2'd1:    status.job_last = !plan_ff[2];
         default: status.job_last = 1'b1;
      endcase
      status.scan_hit = live_ff && rd_valid_ff && (rd_len != 2'd0)
                        && (rd_len == job_len) && (rd_text == job_sym);
      status.scan_end = live_ff && (rd_idx_ff == LAST_ADDR) && !status.scan_hit;
      status.slot_free = !rsp_valid_ff || rsp_bus.ready;
      status.dec_empty = (dcount_ff == 2'd0);
      status.dec_last = ((dk_ff + 2'd1) == dcount_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_special) begin
         res_ff <= special_val;
      end else if (cmd.scan_run && status.scan_hit) begin
         res_ff <= 8'(rd_idx_ff);
      end else if (cmd.scan_run && status.scan_end) begin
         res_ff <= CODE_NONE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.enc_push || cmd.dec_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enc_push) begin
         rsp_byte_ff <= res_ff;
         rsp_last_ff <= status.job_last;
      end else if (cmd.dec_push) begin
         rsp_byte_ff <= dec_shifted[7:0];
         rsp_last_ff <= status.dec_last;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule

// ===== src/tct_controller.sv =====
// controller: sequences lookups, table scans and result pushes
module tct_controller
   import tct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tct_status_type status,
   output tct_cmd_type    cmd
);

   tct_state_type state_ff, state_in;
   logic [1:0] job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            job_in = 2'd0;
            if (status.accept) begin
               case (status.kind)
                  REQ_ENCODE: state_in = ST_ENC_SELECT;
                  REQ_DECODE: state_in = ST_DEC_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENC_SELECT: begin
            if (!status.job_planned) begin
               if (job_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  job_in = job_ff + 2'd1;
               end
            end else if (status.job_special) begin
               state_in = ST_ENC_EMIT;
            end else begin
               state_in = ST_ENC_SCAN;
            end
         end
         ST_ENC_SCAN: begin
            if (status.scan_hit || status.scan_end) begin
               state_in = ST_ENC_EMIT;
            end
         end
         ST_ENC_EMIT: begin
            if (status.slot_free) begin
               if (status.job_last) begin
                  state_in = ST_IDLE;
               end else begin
                  job_in = job_ff + 2'd1;
                  state_in = ST_ENC_SELECT;
               end
            end
         end
         ST_DEC_READ: state_in = ST_DEC_LATCH;
         ST_DEC_LATCH: state_in = ST_DEC_EMIT;
         ST_DEC_EMIT: begin
            if (status.dec_empty) begin
               state_in = ST_IDLE;
            end else if (status.slot_free && status.dec_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.job_sel = job_ff;
      unique case (state_ff)
         ST_IDLE: cmd.ready = 1'b1;
         ST_ENC_SELECT: begin
            cmd.load_special = status.job_planned && status.job_special;
            cmd.scan_start = status.job_planned && !status.job_special;
         end
         ST_ENC_SCAN: cmd.scan_run = 1'b1;
         ST_ENC_EMIT: cmd.enc_push = status.slot_free;
         ST_DEC_READ: ;
         ST_DEC_LATCH: cmd.dec_latch = 1'b1;
         ST_DEC_EMIT: cmd.dec_push = status.slot_free && !status.dec_empty;
         default: ;
      endcase
   end

endmodule

// ===== src/table_charset_transcoder_unit.sv =====
// top level of the table charset transcoder
//
// requests arrive on req_bus: load writes one code table entry, encode takes one
// text byte and gives legacy bytes, decode takes one legacy byte and gives text
// bytes. results leave on rsp_bus, last_of_run marks the final result of a request.
// registers newline_length, newline_first, newline_second are written on the csr
// port (index 0, 1, 2); the user writes them only while no request is in flight,
// which the block itself does not enforce. one request at a time: a load writes
// its entry when accepted, a decode reads the table, latches the entry or the
// newline and emits its bytes, and an encode walks its three lookup slots, giving
// a fixed code or the result of a table scan for each planned one (one entry read
// per cycle from the single table read port, stopping at the lowest matching index).
// results go through one output register, so a request can be accepted while
// the previous result still waits; a stalled receiver holds the controller in
// its emit state until the register drains.
// synchronous reset empties the table (valid bit per entry), clears encoder and
// decoder state and loads the newline defaults (LF, length one).
module table_charset_transcoder_unit
   import tct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   tct_req_if.sink    req_bus,
   tct_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   // command and status between controller and datapath
   tct_cmd_type    cmd;
   tct_status_type status;

   // sequencing of lookups, scans and pushes
   tct_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // table memory, stream state and result register
   tct_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== tb/transcode_checker.sv =====
`timescale 1ns / 1ps
// request monitor, transcoder prediction and result comparison
module transcode_checker
   import tct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_entry_index,
   input  logic [1:0]  req_entry_length,
   input  logic [23:0] req_entry_text,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   output int          mismatch_count,
   output int          expected_count,
   output int          results_seen,
   output int          requests_seen
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } text_out_type;

   text_out_type            expected_bytes_q[$];
   logic [7:0]              step_bytes[$];
   logic [1:0]              code_len [TABLE_ENTRIES];
   logic [SYMBOL_WIDTH-1:0] code_text [TABLE_ENTRIES];
   logic [SYMBOL_WIDTH-1:0] held_symbol = '0;
   int                      held_count = 0;
   logic                    cr_seen = 1'b0;
   logic                    decode_muted = 1'b0;
   logic [1:0]              nl_length = NEWLINE_LENGTH_RESET;
   logic [7:0]              nl_first = NEWLINE_FIRST_RESET;
   logic [7:0]              nl_second = NEWLINE_SECOND_RESET;
   int                      mismatches = 0;
   int                      results = 0;
   int                      requests = 0;

   // fixed codes first, then lowest table index with the same length and text
   function automatic logic [7:0] match_symbol(input logic [SYMBOL_WIDTH-1:0] sym,
                                               input int len);
      if (len == 1 && sym == SYMBOL_WIDTH'(CODE_EOF)) return CODE_EOF;
      if (len == 1 && (sym == SYMBOL_WIDTH'(CODE_CR) || sym == SYMBOL_WIDTH'(CODE_LF)))
         return CODE_CR;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (code_len[i] != 2'd0 && int'(code_len[i]) == len && code_text[i] == sym)
            return 8'(i);
      return CODE_NONE;
   endfunction

   // append one predicted byte of the current request
   task automatic add_step_byte(input logic [7:0] v);
      step_bytes.insert(step_bytes.size(), v);
   endtask

   task automatic flush_held();
      if (held_count != 0) begin
         add_step_byte(match_symbol(held_symbol, held_count));
         held_symbol = '0;
         held_count = 0;
      end
   endtask

   task automatic encode_text_byte(input logic [7:0] b, input logic eot);
      logic consumed;
      consumed = 1'b0;
      if (cr_seen) begin
         cr_seen = 1'b0;
         if (b == CODE_LF) consumed = 1'b1;
      end
      if (!consumed && held_count != 0) begin
         if ((b & CONT_MASK) == CONT_MARK) begin
            held_symbol = held_symbol | (SYMBOL_WIDTH'(b) << (8 * held_count));
            held_count++;
            if (held_count >= SYMBOL_BYTES) flush_held();
            consumed = 1'b1;
         end else begin
            flush_held();
         end
      end
      if (!consumed) begin
         if (b == CODE_CR) begin
            add_step_byte(CODE_CR);
            cr_seen = 1'b1;
         end else if (b == CODE_LF) begin
            add_step_byte(CODE_CR);
         end else if (b[7]) begin
            held_symbol = SYMBOL_WIDTH'(b);
            held_count = 1;
            if (held_count >= SYMBOL_BYTES) flush_held();
         end else begin
            add_step_byte(match_symbol(SYMBOL_WIDTH'(b), 1));
         end
      end
      if (eot) begin
         flush_held();
         cr_seen = 1'b0;
      end
   endtask

   task automatic decode_legacy_byte(input logic [7:0] b, input logic eot);
      if (!decode_muted) begin
         if (b == CODE_EOF) begin
            decode_muted = 1'b1;
         end else if (b == CODE_CR) begin
            add_step_byte(nl_first);
            if (nl_length >= 2'd2) add_step_byte(nl_second);
         end else if (int'(b) < TABLE_ENTRIES) begin
            for (int k = 0; k < int'(code_len[b]); k++)
               add_step_byte(8'(code_text[b] >> (8 * k)));
         end
      end
      if (eot) decode_muted = 1'b0;
   endtask

   task automatic load_code_entry(input logic [7:0] index, input logic [1:0] length,
                                  input logic [23:0] text);
      if (int'(index) < TABLE_ENTRIES) begin
         code_len[index] = length;
         case (length)
            2'd0:    code_text[index] = '0;
            2'd1:    code_text[index] = {16'd0, text[7:0]};
            2'd2:    code_text[index] = {8'd0, text[15:0]};
            default: code_text[index] = text;
         endcase
      end
   endtask

   task automatic transcode_request();
      text_out_type item;
      step_bytes.delete();
      case (req_type)
         REQ_LOAD:   load_code_entry(req_entry_index, req_entry_length, req_entry_text);
         REQ_ENCODE: encode_text_byte(req_data_byte, req_end_of_text);
         REQ_DECODE: decode_legacy_byte(req_data_byte, req_end_of_text);
         default: ;
      endcase
      foreach (step_bytes[k]) begin
         item.value = step_bytes[k];
         item.last = (k == step_bytes.size() - 1);
         expected_bytes_q.insert(expected_bytes_q.size(), item);
      end
   endtask

   task automatic check_result();
      text_out_type want;
      results++;
      if (expected_bytes_q.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result, expected none, got out_byte %02h last %0b",
                  $time, rsp_out_byte, rsp_last_of_run);
      end else begin
         want = expected_bytes_q.pop_front();
         if (rsp_out_byte !== want.value) begin
            mismatches++;
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.value, rsp_out_byte);
         end
         if (rsp_last_of_run !== want.last) begin
            mismatches++;
            $display("%0t: last_of_run expected %0b, got %0b",
                     $time, want.last, rsp_last_of_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            code_len[i] = 2'd0;
            code_text[i] = '0;
         end
         expected_bytes_q.delete();
         held_symbol = '0;
         held_count = 0;
         cr_seen = 1'b0;
         decode_muted = 1'b0;
         nl_length = NEWLINE_LENGTH_RESET;
         nl_first = NEWLINE_FIRST_RESET;
         nl_second = NEWLINE_SECOND_RESET;
         mismatches = 0;
         results = 0;
         requests = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NEWLINE_LENGTH: nl_length = csr_write_data[1:0];
               CSR_NEWLINE_FIRST:  nl_first = csr_write_data;
               CSR_NEWLINE_SECOND: nl_second = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            requests++;
            transcode_request();
         end
      end
      mismatch_count <= mismatches;
      expected_count <= expected_bytes_q.size();
      results_seen <= results;
      requests_seen <= requests;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the table charset transcoder
module tb;
   import tct_pkg::*;

   // request type the block must swallow without effect
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // covers two full table scans plus stalls for a request with no result
   localparam int DRAIN_CYCLES = 700;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int SETTING_COUNT = 5;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   tct_req_if req_bus ();
   tct_rsp_if rsp_bus ();

   int mismatch_count;
   int expected_count;
   int results_seen;
   int requests_seen;
   int cycle_count = 0;

   // stretches with back-to-back traffic on each side
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   // well-formed symbols known to be in the table at some point, used to build text
   logic [23:0] symbol_text[$];
   logic [1:0]  symbol_len[$];
   // indexes that were loaded, so decodes mostly hit real entries
   logic [7:0]  loaded_index[$];

   // new-line settings for the random phases: length, first, second
   logic [1:0] phase_length [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   logic [7:0] phase_first  [4] = '{CODE_CR, 8'hff, 8'h00, 8'h5a};
   logic [7:0] phase_second [4] = '{CODE_LF, 8'h00, 8'hff, 8'ha5};

   always #5 clock = ~clock;

   table_charset_transcoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   transcode_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_type         (req_bus.req_type),
      .req_entry_index  (req_bus.entry_index),
      .req_entry_length (req_bus.entry_length),
      .req_entry_text   (req_bus.entry_text),
      .req_data_byte    (req_bus.data_byte),
      .req_end_of_text  (req_bus.end_of_text),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_out_byte     (rsp_bus.out_byte),
      .rsp_last_of_run  (rsp_bus.last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .expected_count   (expected_count),
      .results_seen     (results_seen),
      .requests_seen    (requests_seen)
   );

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results still owed",
                  cycle_count, expected_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // one request: optional gap, then hold valid until the block takes it
   // valid stays high into the next request when the next gap is zero
   task automatic send_request(input logic [1:0] kind, input logic [7:0] index,
                               input logic [1:0] length, input logic [23:0] text,
                               input logic [7:0] data, input logic eot);
      int gap;
      if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.entry_index  <= index;
      req_bus.entry_length <= length;
      req_bus.entry_text   <= text;
      req_bus.data_byte    <= data;
      req_bus.end_of_text  <= eot;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // fields a request type does not use carry random values
   task automatic load_entry(input logic [7:0] index, input logic [1:0] length,
                             input logic [23:0] text);
      loaded_index.insert(loaded_index.size(), index);
      send_request(REQ_LOAD, index, length, text, 8'($urandom), 1'($urandom));
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic eot);
      send_request(REQ_ENCODE, 8'($urandom), 2'($urandom), 24'($urandom), b, eot);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eot);
      send_request(REQ_DECODE, 8'($urandom), 2'($urandom), 24'($urandom), b, eot);
   endtask

   // table entry: ascii, two- or three-byte symbol, a copy of a known symbol, or junk
   task automatic load_random_entry();
      logic [7:0]  index;
      logic [1:0]  length;
      logic [23:0] text;
      logic        add_symbol;
      int          k;
      index = 8'($urandom);
      add_symbol = 1'b1;
      case ($urandom_range(0, 4))
         0: begin
            length = 2'd1;
            text = {17'd0, 7'($urandom)};
         end
         1: begin
            length = 2'd2;
            text = {8'd0, 2'b10, 6'($urandom), 3'b110, 5'($urandom)};
         end
         2: begin
            length = 2'd3;
            text = {2'b10, 6'($urandom), 2'b10, 6'($urandom), 4'b1110, 4'($urandom)};
         end
         3: begin
            // same symbol at another index, so lowest index has to win
            k = $urandom_range(0, symbol_text.size() - 1);
            length = symbol_len[k];
            text = symbol_text[k];
            add_symbol = 1'b0;
         end
         default: begin
            length = 2'($urandom);
            text = 24'($urandom);
            add_symbol = 1'b0;
         end
      endcase
      if (add_symbol) begin
         symbol_text.insert(symbol_text.size(), text);
         symbol_len.insert(symbol_len.size(), length);
      end
      load_entry(index, length, text);
   endtask

   // loads, whole symbols and line breaks, loose bytes, decodes and odd requests
   task automatic run_random_phase(input int item_count);
      int          sent;
      int          pick;
      int          k;
      logic [1:0]  length;
      logic [23:0] text;
      logic [7:0]  b;
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            load_random_entry();
            sent++;
         end else if (pick < 45) begin
            if ($urandom_range(0, 2) != 0) begin
               k = $urandom_range(0, symbol_text.size() - 1);
               length = symbol_len[k];
               text = symbol_text[k];
            end else begin
               length = 2'd1;
               case ($urandom_range(0, 3))
                  0:       text = {16'd0, CODE_CR};
                  1:       text = {16'd0, CODE_LF};
                  default: text = {17'd0, 7'($urandom)};
               endcase
            end
            for (int i = 0; i < int'(length); i++)
               encode_byte(8'(text >> (8 * i)),
                           i == int'(length) - 1 && $urandom_range(0, 7) == 0);
            sent += int'(length);
         end else if (pick < 60) begin
            // loose byte: broken sequences, stray continuation bytes
            encode_byte(8'($urandom), $urandom_range(0, 9) == 0);
            sent++;
         end else if (pick < 96) begin
            case ($urandom_range(0, 9))
               0:       b = CODE_CR;
               1:       b = CODE_EOF;
               2, 3, 4: b = 8'($urandom);
               default: b = loaded_index[$urandom_range(0, loaded_index.size() - 1)];
            endcase
            decode_byte(b, $urandom_range(0, 5) == 0);
            sent++;
         end else begin
            send_request(REQ_UNUSED, 8'($urandom), 2'($urandom), 24'($urandom),
                         8'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   // drop valid, wait for every owed result, then let the block settle
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // three back-to-back register writes, enable dropped once at the end
   task automatic configure_newline(input logic [7:0] length, input logic [7:0] first,
                                    input logic [7:0] second);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_NEWLINE_LENGTH;
      csr_write_data <= length;
      @(posedge clock);
      csr_index <= CSR_NEWLINE_FIRST;
      csr_write_data <= first;
      @(posedge clock);
      csr_index <= CSR_NEWLINE_SECOND;
      csr_write_data <= second;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stall before each result, with calm stretches
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_NEWLINE_LENGTH;
      csr_write_data <= 8'd0;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= REQ_LOAD;
      req_bus.entry_index <= 8'd0;
      req_bus.entry_length <= 2'd0;
      req_bus.entry_text <= 24'd0;
      req_bus.data_byte <= 8'd0;
      req_bus.end_of_text <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset new-line setting
      // junk above the entry length must be dropped
      load_entry(8'h00, 2'd2, 24'hffa9c2);
      load_entry(8'hff, 2'd3, 24'hac82e2);
      // same symbol at a higher index, index 0x00 must still win
      load_entry(8'h80, 2'd2, 24'h00a9c2);
      load_entry(8'h41, 2'd1, 24'h000041);
      // empty entry, nothing decodes and nothing matches
      load_entry(8'h42, 2'd0, 24'hffffff);
      symbol_text = '{24'h00a9c2, 24'hac82e2, 24'h000041};
      symbol_len  = '{2'd2, 2'd3, 2'd1};

      // two-byte symbol closed by the lead of a three-byte one, which closes itself
      encode_byte(8'hc2, 1'b0);
      encode_byte(8'ha9, 1'b0);
      encode_byte(8'he2, 1'b0);
      encode_byte(8'h82, 1'b0);
      encode_byte(8'hac, 1'b0);
      // broken sequence: lone lead flushed as no-match, then plain ascii
      encode_byte(8'hc2, 1'b0);
      encode_byte(8'h41, 1'b0);
      // cr then lf gives one code, a second lf gives another
      encode_byte(CODE_CR, 1'b0);
      encode_byte(CODE_LF, 1'b0);
      encode_byte(CODE_LF, 1'b0);
      encode_byte(CODE_EOF, 1'b0);
      encode_byte(8'h42, 1'b0);
      // end of text flushes a pending lead and forgets a pending cr
      encode_byte(8'hc2, 1'b1);
      encode_byte(CODE_CR, 1'b1);
      encode_byte(CODE_LF, 1'b0);
      send_request(REQ_UNUSED, 8'hff, 2'd3, 24'hffffff, 8'hff, 1'b1);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'hff, 1'b0);
      decode_byte(CODE_CR, 1'b0);
      // silence until end of data, then output resumes
      decode_byte(CODE_EOF, 1'b0);
      decode_byte(8'h41, 1'b1);
      decode_byte(8'h41, 1'b0);
      wait_until_drained();

      // random phases, one per new-line setting, extremes of every register
      for (int p = 0; p < 4; p++) begin
         configure_newline(8'(phase_length[p]), phase_first[p], phase_second[p]);
         decode_byte(CODE_CR, 1'b1);
         decode_byte(CODE_CR, 1'b1);
         run_random_phase(ITEMS_PER_PHASE);
         wait_until_drained();
      end

      $display("run covered %0d requests and %0d results under %0d new-line settings",
               requests_seen, results_seen, SETTING_COUNT);
      $display("loads, encodes with broken and full symbols, decodes with silencing");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/tct_pkg.sv
src/tct_req_if.sv
src/tct_rsp_if.sv
src/tct_datapath.sv
src/tct_controller.sv
src/table_charset_transcoder_unit.sv
tb/transcode_checker.sv
tb/tb.sv
